### rtl/core/video_line_sync_black_clamp_unit_macros.svh
// Assertion macros shared by the video line sync and black clamp RTL.
`ifndef VIDEO_LINE_SYNC_BLACK_CLAMP_UNIT_MACROS_SVH
`define VIDEO_LINE_SYNC_BLACK_CLAMP_UNIT_MACROS_SVH

// Checks a property on the rising clock edge, ignored while reset is asserted.
`define VLSBC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vlsbc assertion failed");

// Same check with a message of the caller's choosing.
`define VLSBC_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

### rtl/core/vlsbc_pkg.sv
// Package with constants and types of the video line sync and black clamp unit.
package vlsbc_pkg;

    // Field widths.
    localparam int SAMPLE_W = 8;
    localparam int POS_W    = 10;
    localparam int EDGE_W   = 7;
    localparam int INDEX_W  = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Line geometry.
    localparam logic [POS_W-1:0]   LINE_SAMPLES  = 10'd512;
    localparam logic [POS_W-1:0]   SYNC_REF_POS  = 10'd3;
    localparam logic [POS_W-1:0]   SEARCH_END    = 10'd65;
    localparam logic [POS_W-1:0]   BLACK_OFFSET  = 10'd5;
    localparam logic [POS_W-1:0]   ACTIVE_OFFSET = 10'd27;
    localparam logic [POS_W-1:0]   ACTIVE_COUNT  = 10'd319;
    localparam logic [INDEX_W-1:0] LAST_INDEX    = 9'd318;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0]  CFG_SYNC_MARGIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_BLACK_BIAS  = 1'b1;
    localparam logic [CFG_DATA_W-1:0] SYNC_MARGIN_RST = 8'd7;
    localparam logic [CFG_DATA_W-1:0] BLACK_BIAS_RST  = 8'd2;

    // Per-line tracking state.
    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [SAMPLE_W-1:0] threshold;
        logic                edge_found;
        logic [EDGE_W-1:0]   edge_pos;
        logic [SAMPLE_W-1:0] black;
    } t_line_state;

    // One output word.
    typedef struct packed {
        logic [SAMPLE_W-1:0] pixel;
        logic [INDEX_W-1:0]  pixel_index;
        logic                last;
    } t_pixel_word;

endpackage

### rtl/core/vlsbc_in_if.sv
// Sample input channel: valid, ready, one raw video sample word and a line start flag.
interface vlsbc_in_if import vlsbc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                line_start;

    modport source (output valid, output sample, output line_start, input ready);
    modport sink   (input valid, input sample, input line_start, output ready);
endinterface

### rtl/core/vlsbc_out_if.sv
// Pixel output channel: valid, ready and one clamped pixel word.
interface vlsbc_out_if import vlsbc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] pixel;
    logic [INDEX_W-1:0]  pixel_index;
    logic                last;

    modport source (output valid, output pixel, output pixel_index, output last, input ready);
    modport sink   (input valid, input pixel, input pixel_index, input last, output ready);
endinterface

### rtl/core/vlsbc_step.sv
// Combinational per-sample step: sync search, black level capture and clamp.
module vlsbc_step import vlsbc_pkg::*; (
    input  t_line_state         i_state,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_line_start,
    input  logic [SAMPLE_W-1:0] i_sync_margin,
    input  logic [SAMPLE_W-1:0] i_black_bias,
    output t_line_state         o_state,
    output logic                o_emit,
    output t_pixel_word         o_word
);

    t_line_state         eff;
    logic [POS_W-1:0]    p;
    logic [SAMPLE_W-1:0] thr;
    logic [POS_W-1:0]    edge_ext;
    logic [POS_W-1:0]    win_lo;
    logic [POS_W-1:0]    win_hi;
    logic [POS_W-1:0]    idx_full;
    logic [SAMPLE_W-1:0] diff;

    // A line start clears the line state before this sample is handled.
    assign eff = i_line_start ? '0 : i_state;
    assign p   = eff.pos;

    // The threshold is formed from sample 3 and used for that same sample.
    assign thr = (p == SYNC_REF_POS) ? i_sample + i_sync_margin : eff.threshold;

    // Active window bounds relative to the edge.
    assign edge_ext = {{(POS_W-EDGE_W){1'b0}}, eff.edge_pos};
    assign win_lo   = edge_ext + ACTIVE_OFFSET;
    assign win_hi   = win_lo + ACTIVE_COUNT;
    assign idx_full = p - win_lo;
    assign diff     = i_sample - eff.black;

    // Next state and output word.
    always_comb begin
        o_state            = eff;
        o_emit             = 1'b0;
        o_word.pixel       = {diff[SAMPLE_W-2:0], 1'b0};
        o_word.pixel_index = idx_full[INDEX_W-1:0];
        o_word.last        = (idx_full[INDEX_W-1:0] == LAST_INDEX);
        if (p < LINE_SAMPLES) begin
            o_state.pos       = p + 1'b1;
            o_state.threshold = thr;
            if (!eff.edge_found) begin
                if (p >= SYNC_REF_POS && p < SEARCH_END && i_sample > thr) begin
                    o_state.edge_found = 1'b1;
                    o_state.edge_pos   = p[EDGE_W-1:0];
                end else if (p == SEARCH_END) begin
                    o_state.edge_found = 1'b1;
                    o_state.edge_pos   = SEARCH_END[EDGE_W-1:0];
                end
            end else begin
                if (p == edge_ext + BLACK_OFFSET) begin
                    o_state.black = i_sample + i_black_bias;
                end
                if (p >= win_lo && p < win_hi) begin
                    o_emit = 1'b1;
                end
            end
        end
    end

endmodule

### rtl/core/video_line_sync_black_clamp_unit.sv
// Top level of the video line sync search and black clamp unit.
//
// The block takes raw video samples on i_sample_ch, one word per accepted
// handshake, with line_start marking the first sample of each line. Sample 3
// plus the sync margin sets a threshold; the first of samples 3..64 above it
// is the sync edge (65 if none). The sample at edge+5 plus the black bias is
// the black level, and samples edge+27..edge+345 leave on o_pixel_ch as
// pixels 0..318, each (sample - black) * 2 modulo 256, last set on pixel 318.
// Samples outside that window produce no output word.
// Throughput is one sample per cycle while the receiver does not stall: all
// work for a sample is done by one level of logic into the output register,
// and its pixel appears on o_pixel_ch in the cycle after the sample is accepted.
// When the receiver stalls, the output register holds its word and a new
// sample is still accepted in the cycle that word is taken.
// Configuration (sync margin at index 0, black bias at index 1) is written
// through i_cfg_we, i_cfg_idx and i_cfg_data; the user must do so only while
// the block is idle, as the block itself does not enforce it. Synchronous reset
// clears the line state and output valid and sets the margin to 7, bias to 2.
`include "video_line_sync_black_clamp_unit_macros.svh"
module video_line_sync_black_clamp_unit import vlsbc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    vlsbc_in_if.sink              i_sample_ch,
    vlsbc_out_if.source           o_pixel_ch
);

    logic [SAMPLE_W-1:0] r_sync_margin;
    logic [SAMPLE_W-1:0] r_black_bias;
    t_line_state         r_state;
    t_line_state         n_state;
    logic                r_out_valid;
    t_pixel_word         r_word;
    t_pixel_word         n_word;
    logic                n_emit;
    logic                in_accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_margin <= SYNC_MARGIN_RST;
            r_black_bias  <= BLACK_BIAS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SYNC_MARGIN: r_sync_margin <= i_cfg_data;
                CFG_BLACK_BIAS:  r_black_bias  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A new word is taken whenever the output register is free or drains now.
    assign i_sample_ch.ready = !r_out_valid || o_pixel_ch.ready;
    assign in_accept         = i_sample_ch.valid && i_sample_ch.ready;

    // Per-sample line logic.
    vlsbc_step u_step (
        .i_state       (r_state),
        .i_sample      (i_sample_ch.sample),
        .i_line_start  (i_sample_ch.line_start),
        .i_sync_margin (r_sync_margin),
        .i_black_bias  (r_black_bias),
        .o_state       (n_state),
        .o_emit        (n_emit),
        .o_word        (n_word)
    );

    // Line state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_state     <= n_state;
            r_out_valid <= n_emit;
        end else if (o_pixel_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (in_accept && n_emit) begin
            r_word <= n_word;
        end
    end

    assign o_pixel_ch.valid       = r_out_valid;
    assign o_pixel_ch.pixel       = r_word.pixel;
    assign o_pixel_ch.pixel_index = r_word.pixel_index;
    assign o_pixel_ch.last        = r_word.last;

    // Assertions.
    `VLSBC_ASSERT(a_pos_bound, i_clk, i_rst_n, r_state.pos <= LINE_SAMPLES)
    `VLSBC_ASSERT_MSG(a_edge_range, i_clk, i_rst_n, r_state.edge_found |-> (r_state.edge_pos >= SYNC_REF_POS[EDGE_W-1:0] && r_state.edge_pos <= SEARCH_END[EDGE_W-1:0]), "edge position out of search range")
    `VLSBC_ASSERT_MSG(a_black_after_edge, i_clk, i_rst_n, !r_state.edge_found |-> (r_state.black == '0), "black level set before edge found")
    `VLSBC_ASSERT_MSG(a_line_restart, i_clk, i_rst_n, (in_accept && i_sample_ch.line_start) |=> (r_state.pos == 10'd1), "line start did not restart position")

endmodule

### tb/tb_video_line_sync_black_clamp_unit.sv
// Self-checking testbench for the video line sync search and black clamp unit.
`timescale 1ns / 100ps

module tb_video_line_sync_black_clamp_unit;
    import vlsbc_pkg::*;

    localparam int QUIET_LIMIT     = 1000;
    localparam int MAX_REPORTS     = 40;
    localparam int PHASE_SAMPLES   = 60;
    localparam int LONG_LINE_LEN   = 520;
    localparam int FULL_LINE_EXTRA = 346;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    vlsbc_in_if  sample_ch ();
    vlsbc_out_if pixel_ch ();

    video_line_sync_black_clamp_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_sample_ch (sample_ch),
        .o_pixel_ch  (pixel_ch)
    );

    // Predicted registers and line tracking state.
    logic [CFG_DATA_W-1:0] margin_reg;
    logic [CFG_DATA_W-1:0] bias_reg;
    logic [POS_W-1:0]      line_pos;
    logic [SAMPLE_W-1:0]   sync_thr;
    logic                  edge_seen;
    logic [EDGE_W-1:0]     edge_at;
    logic [SAMPLE_W-1:0]   black_lvl;

    // Pixel words predicted but not yet seen on the output.
    t_pixel_word pixel_expect_q[$];

    int error_count  = 0;
    int sent_samples = 0;
    bit send_gaps    = 1'b1;
    bit recv_stalls  = 1'b1;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Prints one mismatch line, up to a cap, and counts every one.
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("MISMATCH at %0t ns: %s", $realtime, what);
        end
    endtask

    task automatic clear_line_state();
        line_pos  = '0;
        sync_thr  = '0;
        edge_seen = 1'b0;
        edge_at   = '0;
        black_lvl = '0;
    endtask

    // Advances the line tracking by one accepted sample and queues the pixel it yields.
    task automatic track_sample(input logic [SAMPLE_W-1:0] s, input logic start);
        int                  p;
        int                  e;
        logic [SAMPLE_W-1:0] diff;
        t_pixel_word         w;
        if (start) begin
            clear_line_state();
        end
        p = line_pos;
        if (p < LINE_SAMPLES) begin
            // The threshold is formed first, so sample 3 is tested against itself plus margin.
            if (p == SYNC_REF_POS) begin
                sync_thr = s + margin_reg;
            end
            if (!edge_seen) begin
                if (p >= SYNC_REF_POS && p < SEARCH_END && s > sync_thr) begin
                    edge_seen = 1'b1;
                    edge_at   = p[EDGE_W-1:0];
                end else if (p == SEARCH_END) begin
                    edge_seen = 1'b1;
                    edge_at   = SEARCH_END[EDGE_W-1:0];
                end
            end else begin
                e = edge_at;
                if (p == e + BLACK_OFFSET) begin
                    black_lvl = s + bias_reg;
                end
                if (p >= e + ACTIVE_OFFSET && p < e + ACTIVE_OFFSET + ACTIVE_COUNT) begin
                    diff          = s - black_lvl;
                    w.pixel       = {diff[SAMPLE_W-2:0], 1'b0};
                    w.pixel_index = INDEX_W'(p - e - ACTIVE_OFFSET);
                    w.last        = (w.pixel_index == LAST_INDEX);
                    pixel_expect_q.push_back(w);
                end
            end
            line_pos = line_pos + 1'b1;
        end
    endtask

    // Follows register writes and accepted samples, and checks each accepted pixel word.
    always @(posedge i_clk) begin : pixel_monitor
        t_pixel_word want;
        if (!i_rst_n) begin
            margin_reg = SYNC_MARGIN_RST;
            bias_reg   = BLACK_BIAS_RST;
            clear_line_state();
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_SYNC_MARGIN: margin_reg = cfg_data;
                    CFG_BLACK_BIAS:  bias_reg   = cfg_data;
                endcase
            end
            if (pixel_ch.valid && pixel_ch.ready) begin
                if (pixel_expect_q.size() == 0) begin
                    report_mismatch($sformatf("pixel word %0d (index %0d) with nothing expected",
                                              pixel_ch.pixel, pixel_ch.pixel_index));
                end else begin
                    want = pixel_expect_q.pop_front();
                    if (pixel_ch.pixel !== want.pixel) begin
                        report_mismatch($sformatf("pixel %0d: value %0d, expected %0d",
                                                  want.pixel_index, pixel_ch.pixel, want.pixel));
                    end
                    if (pixel_ch.pixel_index !== want.pixel_index) begin
                        report_mismatch($sformatf("pixel index %0d, expected %0d",
                                                  pixel_ch.pixel_index, want.pixel_index));
                    end
                    if (pixel_ch.last !== want.last) begin
                        report_mismatch($sformatf("pixel %0d: last %0b, expected %0b",
                                                  want.pixel_index, pixel_ch.last, want.last));
                    end
                end
            end
            if (sample_ch.valid && sample_ch.ready) begin
                track_sample(sample_ch.sample, sample_ch.line_start);
            end
        end
    end

    // Output ready: random stall bursts mixed with open stretches.
    initial begin : pixel_ready_driver
        pixel_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (recv_stalls && $urandom_range(0, 3) == 0) begin
                pixel_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                pixel_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // Ends the run when no word, pixel or register write has moved for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((sample_ch.valid && sample_ch.ready) || (pixel_ch.valid && pixel_ch.ready) ||
                cfg_we) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sends one sample word, sometimes after an idle burst, and waits until it is taken.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic start);
        if (send_gaps && $urandom_range(0, 7) == 0) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.sample     <= s;
        sample_ch.line_start <= start;
        do @(posedge i_clk); while (!sample_ch.ready);
        sent_samples++;
    endtask

    // Holds the input idle until every predicted pixel has come out, then lets the block settle.
    // The queue is checked only once the monitor has tracked the last accepted sample.
    task automatic wait_for_drain();
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pixel_expect_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] margin,
                                  input logic [CFG_DATA_W-1:0] bias);
        wait_for_drain();
        write_register(CFG_SYNC_MARGIN, margin);
        write_register(CFG_BLACK_BIAS, bias);
    endtask

    // Sends a well-formed line aimed to put the sync edge on edge_target (65 means no edge).
    task automatic send_line(input int len, input int edge_target);
        logic [SAMPLE_W-1:0] s;
        logic [SAMPLE_W-1:0] thr;
        int                  pos_i;
        thr = '0;
        for (pos_i = 0; pos_i < len; pos_i++) begin
            s = SAMPLE_W'($urandom_range(0, 255));
            if (pos_i == SYNC_REF_POS) begin
                thr = s + margin_reg;
            end else if (pos_i > SYNC_REF_POS && pos_i < SEARCH_END) begin
                // Keep the search quiet up to the target, then cross the threshold there if it can be crossed.
                if (pos_i < edge_target) begin
                    s = SAMPLE_W'($urandom_range(0, thr));
                end else if (pos_i == edge_target && thr != 8'hFF) begin
                    s = SAMPLE_W'($urandom_range(thr + 1, 255));
                end
            end
            send_sample(s, pos_i == 0);
        end
    endtask

    // Unstructured samples with stray line starts.
    task automatic send_noise(input int len);
        int i;
        for (i = 0; i < len; i++) begin
            send_sample(SAMPLE_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
    endtask

    // Right after reset the position counts from zero without any line start.
    // Sample 3 plus the reset margin wraps, so sample 3 itself is the edge.
    task automatic test_samples_before_line_start();
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd250, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd128, 1'b0);
        send_sample(8'd1, 1'b0);
        send_sample(8'd255, 1'b0);
    endtask

    // A line start mid-line clears the state; a sample equal to the threshold is not an edge.
    task automatic test_threshold_and_short_line();
        send_sample(8'd255, 1'b1);
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd7, 1'b0);
        send_sample(8'd8, 1'b0);
    endtask

    // The margin written early in a line is the one taken at position 3.
    task automatic test_margin_write_mid_line();
        send_sample(8'd0, 1'b1);
        send_sample(8'd255, 1'b0);
        send_sample(8'd128, 1'b0);
        wait_for_drain();
        write_register(CFG_SYNC_MARGIN, 8'hFF);
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd255, 1'b0);
    endtask

    // Random lines over several register settings, extremes included, with idling on both sides.
    task automatic test_random_lines();
        logic [CFG_DATA_W-1:0] margins [4];
        logic [CFG_DATA_W-1:0] biases [4];
        int                    phase_i;
        int                    phase_base;
        int                    pick;
        int                    edge_pick;
        margins[0] = 8'h00;
        biases[0]  = 8'h00;
        margins[1] = 8'hFF;
        biases[1]  = 8'hFF;
        margins[2] = CFG_DATA_W'($urandom_range(1, 254));
        biases[2]  = CFG_DATA_W'($urandom_range(1, 254));
        margins[3] = CFG_DATA_W'($urandom_range(0, 255));
        biases[3]  = CFG_DATA_W'($urandom_range(0, 255));
        for (phase_i = 0; phase_i < 4; phase_i++) begin
            apply_settings(margins[phase_i], biases[phase_i]);
            phase_base = sent_samples;
            while (sent_samples - phase_base < PHASE_SAMPLES) begin
                pick      = $urandom_range(0, 99);
                edge_pick = $urandom_range(4, SEARCH_END);
                if (pick < 65) begin
                    send_line($urandom_range(4, 110), edge_pick);
                end else if (pick < 80) begin
                    send_line(edge_pick + FULL_LINE_EXTRA + $urandom_range(0, 2), edge_pick);
                end else begin
                    send_noise($urandom_range(10, 60));
                end
            end
        end
    endtask

    // A line past the end of the counted samples, with both sides running flat out.
    task automatic test_long_line_no_idle();
        apply_settings(CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'($urandom_range(0, 255)));
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        send_line(LONG_LINE_LEN, $urandom_range(4, SEARCH_END));
    endtask

    // Reset, directed cases, random lines, then the final verdict.
    initial begin : stimulus
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= CFG_SYNC_MARGIN;
        cfg_data             <= '0;
        sample_ch.valid      <= 1'b0;
        sample_ch.sample     <= '0;
        sample_ch.line_start <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_samples_before_line_start();
        test_threshold_and_short_line();
        test_margin_write_mid_line();
        test_random_lines();
        test_long_line_no_idle();

        wait_for_drain();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/vlsbc_pkg.sv
rtl/core/vlsbc_in_if.sv
rtl/core/vlsbc_out_if.sv
rtl/core/vlsbc_step.sv
rtl/core/video_line_sync_black_clamp_unit.sv
tb/tb_video_line_sync_black_clamp_unit.sv
